[sv/qsmp_pkg.sv]
// ============================================================================
// qsmp_pkg
// Shared types and constants for the quintic servo motion profiler.
// ============================================================================
package qsmp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PMIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PMAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP   = 3'd4;

    localparam int DUR_W        = 20;
    localparam int JUMP_LIMIT   = 15;
    localparam int MIN_DURATION = 60;
    localparam int MAX_DEG      = 180;

    // floor(x/180) = floor(floor(x/4) * RECIP_45 / 2^RECIP_SHIFT) for x < 2^20
    localparam int          RECIP_SHIFT = 24;
    localparam logic [18:0] RECIP_45    = 19'd372828;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLAN,
        S_DUR_MUL,
        S_DUR_WR,
        S_ELAPSED,
        S_DIV,
        S_MUL_TT,
        S_MUL_T3,
        S_MUL_E,
        S_MUL_STEP,
        S_POS,
        S_ROUND,
        S_MAP_MUL,
        S_MAP_RECIP,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PLAN,
        OP_DUR_MUL,
        OP_DUR_WR,
        OP_ELAPSED,
        OP_DIV,
        OP_MUL_TT,
        OP_MUL_T3,
        OP_MUL_E,
        OP_MUL_STEP,
        OP_POS,
        OP_ROUND,
        OP_MAP_MUL,
        OP_MAP_RECIP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic snap;
        logic replan;
        logic skip_ease;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

[sv/qsmp_ctrl.sv]
// ============================================================================
// qsmp_ctrl
// Sequencer: steps the datapath through plan, divide, ease and mapping.
// ============================================================================
module qsmp_ctrl import qsmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_op     o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_status.snap) begin
                    n_state = S_ROUND;
                end else if (i_status.replan) begin
                    n_state = S_DUR_MUL;
                end else begin
                    n_state = S_ELAPSED;
                end
            end
            S_DUR_MUL:   n_state = S_DUR_WR;
            S_DUR_WR:    n_state = S_ELAPSED;
            S_ELAPSED: begin
                n_state = i_status.skip_ease ? S_ROUND : S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_MUL_TT;
                end
            end
            S_MUL_TT:    n_state = S_MUL_T3;
            S_MUL_T3:    n_state = S_MUL_E;
            S_MUL_E:     n_state = S_MUL_STEP;
            S_MUL_STEP:  n_state = S_POS;
            S_POS:       n_state = S_ROUND;
            S_ROUND:     n_state = S_MAP_MUL;
            S_MAP_MUL:   n_state = S_MAP_RECIP;
            S_MAP_RECIP: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_op       = i_in_valid ? OP_LOAD : OP_NONE;
            end
            S_PLAN:      o_op = OP_PLAN;
            S_DUR_MUL:   o_op = OP_DUR_MUL;
            S_DUR_WR:    o_op = OP_DUR_WR;
            S_ELAPSED:   o_op = OP_ELAPSED;
            S_DIV:       o_op = OP_DIV;
            S_MUL_TT:    o_op = OP_MUL_TT;
            S_MUL_T3:    o_op = OP_MUL_T3;
            S_MUL_E:     o_op = OP_MUL_E;
            S_MUL_STEP:  o_op = OP_MUL_STEP;
            S_POS:       o_op = OP_POS;
            S_ROUND:     o_op = OP_ROUND;
            S_MAP_MUL:   o_op = OP_MAP_MUL;
            S_MAP_RECIP: o_op = OP_MAP_RECIP;
            S_EMIT:      o_op = i_status.out_free ? OP_EMIT : OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end

endmodule

[sv/qsmp_datapath.sv]
// ============================================================================
// qsmp_datapath
// Axis state, config registers, serial divider, shared multiplier, output reg.
// ============================================================================
module qsmp_datapath import qsmp_pkg::*; #(
    parameter int FRAC_BITS  = 8,
    parameter int EASE_BITS  = 16,
    parameter int HOME_ANGLE = 90
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_op                   i_op,
    output t_status               o_status,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]           i_now_ms,
    input  logic signed [9:0]     i_target_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [9:0]     o_angle_now,
    output logic                  o_moved,
    output logic [11:0]           o_pulse_off
);

    localparam int AW    = 11;
    localparam int PW    = FRAC_BITS + 11;
    localparam int MAG_W = FRAC_BITS + 10;
    localparam int QW    = EASE_BITS + 4;
    localparam int MW_0  = (MAG_W > QW) ? MAG_W : QW;
    localparam int MW    = (MW_0 > 19) ? MW_0 : 19;
    localparam int PRW   = 2 * MW;
    localparam int CW    = $clog2(EASE_BITS);
    localparam int TW    = 2 * EASE_BITS;

    localparam logic signed [PW-1:0] HOME_Q    = PW'(HOME_ANGLE * (2 ** FRAC_BITS));
    localparam logic signed [AW-1:0] HOME_A    = AW'(HOME_ANGLE);
    localparam logic signed [PW-1:0] HALF_Q    = PW'(2 ** (FRAC_BITS - 1));
    localparam logic [QW:0]          TEN_ONE   = (QW + 1)'(10) << EASE_BITS;

    // configuration
    logic [9:0]         r_speed;
    logic signed [7:0]  r_offset;
    logic [11:0]        r_pmin;
    logic [11:0]        r_pmax;
    logic               r_snap;

    // axis state
    logic signed [AW-1:0] r_planned;
    logic signed [PW-1:0] r_start_pos;
    logic signed [PW-1:0] r_exact;
    logic [31:0]          r_start_time;
    logic [DUR_W-1:0]     r_dur;
    logic signed [AW-1:0] r_round;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_valid;

    // working registers
    logic [31:0]          r_now;
    logic signed [9:0]    r_target;
    logic [DUR_W-1:0]     r_rem;
    logic [EASE_BITS-1:0] r_quo;
    logic [PRW-1:0]       r_prod;
    logic [QW-1:0]        r_q;
    logic                 r_moved;
    logic signed [9:0]    r_out_angle;
    logic                 r_out_moved;
    logic [11:0]          r_out_pulse;

    logic signed [PW-1:0] w_target_q;
    logic signed [AW-1:0] w_target_a;
    logic signed [AW:0]   w_delta;
    logic signed [AW:0]   w_delta_neg;
    logic [AW:0]          w_abs_delta;
    logic signed [PW-1:0] w_exact_half;
    logic signed [AW-1:0] w_exact_rnd;
    logic                 w_changed;
    logic                 w_replan;
    logic signed [PW-1:0] w_diff;
    logic signed [PW-1:0] w_diff_neg;
    logic [MAG_W-1:0]     w_diff_mag;
    logic signed [PW-1:0] w_d;
    logic signed [PW-1:0] w_d_neg;
    logic [MAG_W-1:0]     w_d_mag;
    logic                 w_at_target;
    logic [31:0]          w_elapsed;
    logic                 w_elapsed_done;
    logic [DUR_W:0]       w_rem2;
    logic [DUR_W:0]       w_rem_sub;
    logic                 w_rem_ge;
    logic [MW-1:0]        w_hi_e;
    logic [TW-1:0]        w_tt;
    logic [TW+2:0]        w_six_tt;
    logic [QW:0]          w_fifteen_t;
    logic [QW:0]          w_q_full;
    logic signed [PW-1:0] w_step;
    logic [DUR_W-1:0]     w_dur_raw;
    logic signed [AW:0]   w_a_sum;
    logic [7:0]           w_a_clamp;
    logic                 w_range_neg;
    logic [11:0]          w_range_mag;
    logic [11:0]          w_frac;
    logic [11:0]          w_pulse;
    logic [MW-1:0]        w_mul_a;
    logic [MW-1:0]        w_mul_b;
    logic [PRW-1:0]       w_mul;
    logic                 w_out_free;

    // ---------------- plan and timing ----------------
    assign w_target_q   = {r_target[9], r_target, {FRAC_BITS{1'b0}}};
    assign w_target_a   = {r_target[9], r_target};
    assign w_delta      = {w_target_a[AW-1], w_target_a} - {r_planned[AW-1], r_planned};
    assign w_delta_neg  = -w_delta;
    assign w_abs_delta  = w_delta[AW] ? w_delta_neg : w_delta;
    assign w_exact_half = r_exact + HALF_Q;
    assign w_exact_rnd  = w_exact_half[PW-1:FRAC_BITS];
    assign w_changed    = (w_target_a != r_planned);
    assign w_replan     = w_changed &&
                          ((w_exact_rnd == r_planned) || (w_abs_delta > (AW + 1)'(JUMP_LIMIT)));

    assign w_diff       = w_target_q - r_exact;
    assign w_diff_neg   = -w_diff;
    assign w_diff_mag   = w_diff[PW-1] ? w_diff_neg[MAG_W-1:0] : w_diff[MAG_W-1:0];
    assign w_d          = w_target_q - r_start_pos;
    assign w_d_neg      = -w_d;
    assign w_d_mag      = w_d[PW-1] ? w_d_neg[MAG_W-1:0] : w_d[MAG_W-1:0];

    assign w_at_target    = (r_exact == w_target_q);
    assign w_elapsed      = r_now - r_start_time;
    assign w_elapsed_done = (w_elapsed >= 32'(r_dur));
    assign w_dur_raw      = r_prod[FRAC_BITS +: DUR_W];

    // ---------------- restoring divider ----------------
    assign w_rem2    = {r_rem, 1'b0};
    assign w_rem_ge  = (w_rem2 >= {1'b0, r_dur});
    assign w_rem_sub = w_rem2 - {1'b0, r_dur};

    // ---------------- ease polynomial ----------------
    assign w_hi_e      = r_prod[EASE_BITS +: MW];
    assign w_tt        = r_prod[TW-1:0];
    assign w_six_tt    = {1'b0, w_tt, 2'b00} + {2'b00, w_tt, 1'b0};
    assign w_fifteen_t = {1'b0, r_quo, 4'b0000} - {5'b00000, r_quo};
    assign w_q_full    = TEN_ONE + (QW + 1)'(w_six_tt[TW+2:EASE_BITS]) - w_fifteen_t;
    assign w_step      = $signed(r_prod[EASE_BITS +: PW]);

    // ---------------- pulse mapping ----------------
    assign w_a_sum     = {r_round[AW-1], r_round} + (AW + 1)'(r_offset);
    assign w_range_neg = (r_pmax < r_pmin);
    assign w_range_mag = w_range_neg ? (r_pmin - r_pmax) : (r_pmax - r_pmin);
    assign w_frac      = r_prod[RECIP_SHIFT +: 12];
    assign w_pulse     = w_range_neg ? (r_pmin - w_frac) : (r_pmin + w_frac);

    always_comb begin
        if (w_a_sum[AW]) begin
            w_a_clamp = 8'd0;
        end else if (w_a_sum > $signed((AW + 1)'(MAX_DEG))) begin
            w_a_clamp = 8'(MAX_DEG);
        end else begin
            w_a_clamp = w_a_sum[7:0];
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_op)
            OP_DUR_MUL: begin
                w_mul_a = MW'(w_diff_mag);
                w_mul_b = MW'(r_speed);
            end
            OP_MUL_TT: begin
                w_mul_a = MW'(r_quo);
                w_mul_b = MW'(r_quo);
            end
            OP_MUL_T3: begin
                w_mul_a = w_hi_e;
                w_mul_b = MW'(r_quo);
            end
            OP_MUL_E: begin
                w_mul_a = w_hi_e;
                w_mul_b = MW'(r_q);
            end
            OP_MUL_STEP: begin
                w_mul_a = MW'(w_d_mag);
                w_mul_b = w_hi_e;
            end
            OP_MAP_MUL: begin
                w_mul_a = MW'(w_a_clamp);
                w_mul_b = MW'(w_range_mag);
            end
            OP_MAP_RECIP: begin
                w_mul_a = MW'(r_prod[2 +: 18]);
                w_mul_b = MW'(RECIP_45);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    assign w_out_free = !r_out_valid || i_out_ready;

    // ---------------- state with reset ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed      <= 10'd10;
            r_offset     <= 8'sd0;
            r_pmin       <= 12'd102;
            r_pmax       <= 12'd512;
            r_snap       <= 1'b0;
            r_planned    <= HOME_A;
            r_start_pos  <= HOME_Q;
            r_exact      <= HOME_Q;
            r_start_time <= '0;
            r_dur        <= '0;
            r_round      <= HOME_A;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED:  r_speed  <= i_cfg_data[9:0];
                    CFG_OFFSET: r_offset <= $signed(i_cfg_data[7:0]);
                    CFG_PMIN:   r_pmin   <= i_cfg_data;
                    CFG_PMAX:   r_pmax   <= i_cfg_data;
                    CFG_SNAP:   r_snap   <= i_cfg_data[0];
                    default:    ;
                endcase
            end

            if (i_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (i_op)
                OP_PLAN: begin
                    if (r_snap) begin
                        r_planned   <= w_target_a;
                        r_start_pos <= w_target_q;
                        r_exact     <= w_target_q;
                    end else if (w_changed) begin
                        if (w_replan) begin
                            r_start_pos  <= r_exact;
                            r_start_time <= r_now;
                        end
                        r_planned <= w_target_a;
                    end
                end
                OP_DUR_WR: begin
                    r_dur <= (w_dur_raw < DUR_W'(MIN_DURATION)) ? DUR_W'(MIN_DURATION)
                                                                 : w_dur_raw;
                end
                OP_ELAPSED: begin
                    if (!w_at_target && w_elapsed_done) begin
                        r_exact <= w_target_q;
                    end
                    r_cnt <= '0;
                end
                OP_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_POS: begin
                    r_exact <= w_d[PW-1] ? (r_start_pos - w_step) : (r_start_pos + w_step);
                end
                OP_ROUND: begin
                    r_round <= w_exact_rnd;
                end
                default: ;
            endcase
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_now    <= i_now_ms;
                r_target <= i_target_angle;
            end
            OP_ELAPSED: begin
                r_rem <= w_elapsed[DUR_W-1:0];
                r_quo <= '0;
            end
            OP_DIV: begin
                r_rem <= w_rem_ge ? w_rem_sub[DUR_W-1:0] : w_rem2[DUR_W-1:0];
                r_quo <= {r_quo[EASE_BITS-2:0], w_rem_ge};
            end
            OP_DUR_MUL, OP_MUL_TT, OP_MUL_E, OP_MUL_STEP, OP_MAP_MUL, OP_MAP_RECIP: begin
                r_prod <= w_mul;
            end
            OP_MUL_T3: begin
                r_prod <= w_mul;
                r_q    <= w_q_full[QW-1:0];
            end
            OP_ROUND: begin
                r_moved <= (w_exact_rnd != r_round);
            end
            OP_EMIT: begin
                r_out_angle <= r_round[9:0];
                r_out_moved <= r_moved;
                r_out_pulse <= w_pulse;
            end
            default: ;
        endcase
    end

    assign o_status.snap      = r_snap;
    assign o_status.replan    = w_replan;
    assign o_status.skip_ease = w_at_target || w_elapsed_done;
    assign o_status.div_last  = (r_cnt == CW'(EASE_BITS - 1));
    assign o_status.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_angle_now = r_out_angle;
    assign o_moved     = r_out_moved;
    assign o_pulse_off = r_out_pulse;

endmodule

[sv/quintic_servo_motion_profiler_top.sv]
// ============================================================================
// quintic_servo_motion_profiler_top
// One servo axis: quintic-eased position and PWM off-count per update tick.
// ============================================================================
// Sequence: plan, then (after a replan) duration multiply and write, elapsed
//   check, divide and ease, rounding, pulse mapping and emit; snap mode goes
//   from plan to rounding, and a tick that needs no easing skips divide and ease.
// Flow: one transaction at a time, taken only in idle; a new tick waits for the
//   EASE_BITS-step serial divider and the shared multiplier (up to seven passes).
// Reset (synchronous, active low): axis at HOME_ANGLE, registers at defaults.
module quintic_servo_motion_profiler_top import qsmp_pkg::*; #(
    parameter int FRAC_BITS  = 8,
    parameter int EASE_BITS  = 16,
    parameter int HOME_ANGLE = 90
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic signed [9:0]     i_target_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [9:0]     o_angle_now,
    output logic                  o_moved,
    output logic [11:0]           o_pulse_off,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_op     w_op;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    qsmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    qsmp_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .EASE_BITS  (EASE_BITS),
        .HOME_ANGLE (HOME_ANGLE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_now_ms       (i_now_ms),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_angle_now    (o_angle_now),
        .o_moved        (o_moved),
        .o_pulse_off    (o_pulse_off)
    );

endmodule

[sv/qsmp_checker.sv]
// ============================================================================
// qsmp_port_checks
// Port-level checks for the motion profiler, bound to the top level.
// ============================================================================
module qsmp_port_checks #(
    parameter int HOME_ANGLE = 90
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic signed [9:0] o_angle_now,
    input logic              o_moved,
    input logic [11:0]       o_pulse_off
);

    logic signed [9:0] r_last_angle;

    // angle of the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= 10'(HOME_ANGLE);
        end else if (o_out_valid && i_out_ready) begin
            r_last_angle <= o_angle_now;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_angle_now) && $stable(o_moved) && $stable(o_pulse_off))
        else $error("output changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready))
        else $error("input ready dropped without a transaction");

    a_moved_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_moved == (o_angle_now != r_last_angle)))
        else $error("moved flag disagrees with angle change");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind quintic_servo_motion_profiler_top qsmp_port_checks #(
    .HOME_ANGLE (HOME_ANGLE)
) u_qsmp_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_angle_now (o_angle_now),
    .o_moved     (o_moved),
    .o_pulse_off (o_pulse_off)
);

[tb/qsmp_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// qsmp_checker
// Watches the tick, pulse and register channels of the servo profiler, tracks
// the axis and the register copy, and compares every pulse command against
// the tracked eased angle, moved flag and PWM off-count.
// ============================================================================
module qsmp_checker import qsmp_pkg::*; #(
    parameter int FRAC_BITS  = 8,
    parameter int EASE_BITS  = 16,
    parameter int HOME_ANGLE = 90
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [31:0]           i_now_ms,
    input  logic signed [9:0]     i_target_angle,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic signed [9:0]     i_angle_now,
    input  logic                  i_moved,
    input  logic [11:0]           i_pulse_off,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_moves
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [9:0] angle;
        logic              moved;
        logic [11:0]       pulse;
    } t_servo_cmd;

    localparam longint ONE_Q  = longint'(1) <<< FRAC_BITS;
    localparam longint HALF_Q = longint'(1) <<< (FRAC_BITS - 1);
    localparam u64_t   ONE_E  = u64_t'(1) << EASE_BITS;

    logic [9:0]         speed;
    logic signed [7:0]  trim;
    logic [11:0]        pmin;
    logic [11:0]        pmax;
    logic               snap;

    int                 plan_target;
    longint             origin_q;
    longint             pos_q;
    logic [31:0]        origin_ms;
    logic [19:0]        span_ms;
    int                 shown_deg;

    t_servo_cmd         servo_cmd_q[$];
    int                 fail_total;
    int                 checked_total;
    int                 moves_total;

    function automatic int whole_deg(input longint pos);
        return int'((pos + HALF_Q) >>> FRAC_BITS);
    endfunction

    function automatic void home_axis();
        speed       = 10'd10;
        trim        = 8'sd0;
        pmin        = 12'd102;
        pmax        = 12'd512;
        snap        = 1'b0;
        plan_target = HOME_ANGLE;
        origin_q    = longint'(HOME_ANGLE) * ONE_Q;
        pos_q       = longint'(HOME_ANGLE) * ONE_Q;
        origin_ms   = '0;
        span_ms     = '0;
        shown_deg   = HOME_ANGLE;
    endfunction

    function automatic void latch_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SPEED:  speed = data[9:0];
            CFG_OFFSET: trim  = data[7:0];
            CFG_PMIN:   pmin  = data[11:0];
            CFG_PMAX:   pmax  = data[11:0];
            CFG_SNAP:   snap  = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_servo_cmd track_axis(input logic [31:0] now,
                                              input logic signed [9:0] tgt_in);
        int          tgt;
        int          jump;
        int          deg_now;
        longint      tgt_q;
        longint      dist_q;
        longint      d;
        longint      step;
        longint      deg;
        longint      span;
        longint      prod;
        u64_t        plan_ms;
        u64_t        t;
        u64_t        t2;
        u64_t        t3;
        u64_t        q;
        u64_t        e;
        u64_t        mag;
        logic [31:0] elapsed;
        t_servo_cmd  cmd;

        tgt       = tgt_in;
        tgt_q     = longint'(tgt) * ONE_Q;
        cmd.moved = 1'b0;
        if (snap) begin
            plan_target = tgt;
            origin_q    = tgt_q;
            pos_q       = tgt_q;
        end else begin
            if (tgt != plan_target) begin
                jump = tgt - plan_target;
                if (jump < 0) jump = -jump;
                if (whole_deg(pos_q) == plan_target || jump > JUMP_LIMIT) begin
                    dist_q = tgt_q - pos_q;
                    if (dist_q < 0) dist_q = -dist_q;
                    origin_q  = pos_q;
                    origin_ms = now;
                    plan_ms   = (u64_t'(dist_q) * speed) >> FRAC_BITS;
                    if (plan_ms < MIN_DURATION) plan_ms = MIN_DURATION;
                    span_ms = 20'(plan_ms);
                end
                plan_target = tgt;
            end
            if (pos_q != tgt_q) begin
                elapsed = now - origin_ms;
                if (elapsed >= span_ms) begin
                    pos_q = tgt_q;
                end else begin
                    t     = (u64_t'(elapsed) << EASE_BITS) / span_ms;
                    t2    = (t * t) >> EASE_BITS;
                    t3    = (t2 * t) >> EASE_BITS;
                    q     = 10 * ONE_E + ((6 * t * t) >> EASE_BITS) - 15 * t;
                    e     = (t3 * q) >> EASE_BITS;
                    d     = tgt_q - origin_q;
                    mag   = (d < 0) ? -d : d;
                    step  = (mag * e) >> EASE_BITS;
                    pos_q = (d < 0) ? origin_q - step : origin_q + step;
                end
            end
        end

        deg_now = whole_deg(pos_q);
        if (deg_now != shown_deg) begin
            shown_deg = deg_now;
            cmd.moved = 1'b1;
        end

        deg = shown_deg + trim;
        if (deg < 0) deg = 0;
        if (deg > MAX_DEG) deg = MAX_DEG;
        span      = longint'(pmax) - longint'(pmin);
        prod      = deg * span;
        cmd.angle = 10'(shown_deg);
        cmd.pulse = 12'(longint'(pmin) + prod / MAX_DEG);
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        t_servo_cmd exp_cmd;
        if (!i_rst_n) begin
            home_axis();
            servo_cmd_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                latch_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                servo_cmd_q.push_back(track_axis(i_now_ms, i_target_angle));
            end
            if (i_out_valid && i_out_ready) begin
                if (servo_cmd_q.size() == 0) begin
                    $error("pulse command with no tick pending: angle_now %0d",
                           i_angle_now);
                    fail_total++;
                end else begin
                    exp_cmd = servo_cmd_q.pop_front();
                    checked_total++;
                    if (exp_cmd.moved) moves_total++;
                    if (i_angle_now !== exp_cmd.angle) begin
                        $error("angle_now mismatch: expected %0d, actual %0d",
                               exp_cmd.angle, i_angle_now);
                        fail_total++;
                    end
                    if (i_moved !== exp_cmd.moved) begin
                        $error("moved mismatch: expected %0d, actual %0d",
                               exp_cmd.moved, i_moved);
                        fail_total++;
                    end
                    if (i_pulse_off !== exp_cmd.pulse) begin
                        $error("pulse_off mismatch: expected %0d, actual %0d",
                               exp_cmd.pulse, i_pulse_off);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= servo_cmd_q.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_moves      <= moves_total;
    end

endmodule

[tb/tb_quintic_servo_motion_profiler_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_quintic_servo_motion_profiler_top
// Drives ticks and register writes into the servo profiler: a directed pass
// over move planning, endpoint nudges, time wrap, snap mode and reversed
// pulse ranges, then random move sequences under six register settings with
// idle bursts on both channels in all but the last. Checking lives in qsmp_checker.
// ============================================================================
module tb_quintic_servo_motion_profiler_top import qsmp_pkg::*; ();

    localparam int FRAC_BITS       = 8;
    localparam int EASE_BITS       = 16;
    localparam int HOME_ANGLE      = 90;
    localparam int DRAIN_CYCLES    = EASE_BITS + 20;
    localparam int LONG_HOLD       = 400;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 334;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [31:0]           now_ms;
    logic signed [9:0]     target_angle;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [9:0]     angle_now;
    logic                  moved;
    logic [11:0]           pulse_off;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int moves;

    bit feed_gaps;
    bit sink_stalls;
    int hold_requests;
    int holds_served;
    int ticks_sent;
    int settings_used;

    quintic_servo_motion_profiler_top #(
        .FRAC_BITS  (FRAC_BITS),
        .EASE_BITS  (EASE_BITS),
        .HOME_ANGLE (HOME_ANGLE)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_now_ms       (now_ms),
        .i_target_angle (target_angle),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_angle_now    (angle_now),
        .o_moved        (moved),
        .o_pulse_off    (pulse_off),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    qsmp_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .EASE_BITS  (EASE_BITS),
        .HOME_ANGLE (HOME_ANGLE)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_now_ms       (now_ms),
        .i_target_angle (target_angle),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_angle_now    (angle_now),
        .i_moved        (moved),
        .i_pulse_off    (pulse_off),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_moves        (moves)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // pulse command sink: random stall bursts plus requested long hold-offs
    initial begin
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic [31:0] ms, input int tgt);
        if (feed_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        now_ms       <= ms;
        target_angle <= 10'(tgt);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain_axis();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic post_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_axis_regs(input logic [9:0] spd, input logic signed [7:0] trim,
                                 input logic [11:0] lo, input logic [11:0] hi,
                                 input logic snp);
        post_reg(CFG_SPEED, 12'(spd));
        post_reg(CFG_OFFSET, 12'(trim));
        post_reg(CFG_PMIN, lo);
        post_reg(CFG_PMAX, hi);
        post_reg(CFG_SNAP, {11'd0, snp});
        settings_used++;
    endtask

    initial begin
        int          p;
        int          n;
        int          r;
        int          cur_tgt;
        int          tgt;
        int          step_max;
        logic [9:0]  spd;
        logic [31:0] clock_ms;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        now_ms       <= '0;
        target_angle <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        feed_gaps     = 1'b1;
        sink_stalls   = 1'b1;
        settings_used = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(32'd0, 90);
        send_tick(32'd100, 360);
        send_tick(32'd1450, 360);
        send_tick(32'd1460, 350);
        send_tick(32'd2000, 350);
        send_tick(32'd2900, 350);
        send_tick(32'd2910, -360);
        send_tick(32'd3000, -345);
        send_tick(32'd3010, -329);
        send_tick(32'hFFFF_FFF0, -329);
        send_tick(32'hFFFF_FFF8, -320);
        send_tick(32'h0000_0020, -320);
        send_tick(32'h0000_0030, -322);
        send_tick(32'hFFFF_FFFF, -322);

        drain_axis();
        set_axis_regs(10'd0, -8'sd90, 12'd4095, 12'd0, 1'b0);
        send_tick(32'd200, 180);
        send_tick(32'd230, 180);
        send_tick(32'd400, 180);

        drain_axis();
        set_axis_regs(10'd1000, 8'sd90, 12'd0, 12'd4095, 1'b1);
        send_tick(32'd500, 360);
        send_tick(32'd510, -360);
        send_tick(32'd520, 0);
        drain_axis();
        post_reg(CFG_UNUSED_LO, 12'hFFF);
        post_reg(CFG_UNUSED_HI, 12'hFFF);
        send_tick(32'd530, 45);
        drain_axis();
        post_reg(CFG_SNAP, 12'd0);
        send_tick(32'd540, 100);
        send_tick(32'd28040, 100);

        for (p = 0; p < PHASES; p++) begin
            drain_axis();
            feed_gaps   = (p != PHASES - 1);
            sink_stalls = (p != PHASES - 1);
            case (p)
                0: spd = 10'd1000;
                1: spd = 10'd0;
                default: spd = 10'($urandom_range(1, 40));
            endcase
            case (p)
                0: set_axis_regs(spd, 8'sd90, 12'd0, 12'd4095, 1'b0);
                1: set_axis_regs(spd, -8'sd90, 12'd4095, 12'd0, 1'b0);
                default: set_axis_regs(spd, 8'(int'($urandom_range(0, 180)) - 90),
                                       12'($urandom()), 12'($urandom()), p == 3);
            endcase
            step_max = 3 * spd + 20;
            clock_ms = (p == 4) ? 32'hFFFF_8000 : $urandom();
            cur_tgt  = int'($urandom_range(0, 720)) - 360;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == 50) hold_requests++;
                if (p == 2 && n == 150) drain_axis();
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_tick($urandom(), int'($urandom_range(0, 720)) - 360);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                    if (r < 20) begin
                        cur_tgt = int'($urandom_range(0, 720)) - 360;
                    end else if (r < 35) begin
                        tgt = cur_tgt + int'($urandom_range(0, 32)) - 16;
                        if (tgt > 360) tgt = 360;
                        if (tgt < -360) tgt = -360;
                        cur_tgt = tgt;
                    end
                    send_tick(clock_ms, cur_tgt);
                end
            end
        end

        drain_axis();
        $display("Covered %0d ticks over %0d register settings (eased, snapped, wrapped,",
                 ticks_sent, settings_used);
        $display("  reversed and zero-speed), %0d pulse commands checked, %0d angle changes",
                 checked, moves);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
